// ===== design/ttb_pkg.sv =====
`timescale 1ns / 1ps
package ttb_pkg;

    localparam int FIELD_W     = 32;
    localparam int OUT_W       = 16;
    localparam int COORD_W     = 32;
    localparam int UNIT_FRAC   = 14;
    localparam int CORNER_FLDS = 5;
    localparam int HELD_DEPTH  = 2 * CORNER_FLDS;
    localparam int ED_DEPTH    = 10;
    localparam int RES_DEPTH   = 7;
    localparam int UV_DEPTH    = 6;

    localparam int DIFF_W  = COORD_W + 1;
    localparam int MUL_W   = (DIFF_W > 32) ? DIFF_W : 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 2 * DIFF_W + 1;
    localparam int P_W     = $clog2(ACC_W);
    localparam int NORM_TOP = 30;
    localparam int NM_W    = NORM_TOP + 1;
    localparam int SUM_W   = 64;
    localparam int LEN_W   = 32;
    localparam int QB      = UNIT_FRAC + 1;
    localparam int NUM_W   = NM_W + UNIT_FRAC + 1;
    localparam int DV_W    = NUM_W + 1;
    localparam int STEP_W  = 6;
    localparam int MUL_STEPS  = 14;
    localparam int SQ_STEPS   = 3;
    localparam int ROOT_STEPS = SUM_W / 2;

    // result slots of the product/difference pass
    localparam int RES_DET = 0;
    localparam int RES_T   = 1;
    localparam int RES_B   = 4;

    // edge / delta slots
    localparam int ED_E1  = 0;
    localparam int ED_E2  = 3;
    localparam int ED_DU1 = 6;
    localparam int ED_DV1 = 7;
    localparam int ED_DU2 = 8;
    localparam int ED_DV2 = 9;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MUL    = 8'b0000_0010,
        ST_SCAN   = 8'b0000_0100,
        ST_SHIFT  = 8'b0000_1000,
        ST_SQR    = 8'b0001_0000,
        ST_ROOT   = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    function automatic logic signed [DIFF_W-1:0] coord_diff(
        input logic [FIELD_W-1:0] a,
        input logic [FIELD_W-1:0] b
    );
        logic signed [COORD_W-1:0] sa;
        logic signed [COORD_W-1:0] sb;
        sa = $signed(a[COORD_W-1:0]);
        sb = $signed(b[COORD_W-1:0]);
        return DIFF_W'(sa) - DIFF_W'(sb);
    endfunction

endpackage

// ===== design/triangle_tangent_binormal.sv =====
`timescale 1ns / 1ps
// Channel | Ports                                   | Direction
// s_      | pos_x/y/z, tex_u/v, mesh_start          | vertex request in
// m_      | tangent_x/y/z, binormal_x/y/z, degenerate | one result per triangle
//
// Corner 0 and 1 vertices are stored in the held registers as they are taken.
// A third-corner vertex starts a run on one shared 33x33 multiplier, a
// binary top-bit search, a bit-pair square root and a restoring divider:
// first the products and differences, then per vector scan, shift, square,
// root and divide. m_valid rises when the finish step loads the output
// register (a zero determinant goes straight there); s_ready is low for the whole run.
// aresetn (synchronous) clears the corner count, the sequencer and m_valid.
// A finished result waits in the output register while vertices keep coming;
// a second triangle stalls in its last step until that register is free.
module triangle_tangent_binormal (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ttb_pkg::FIELD_W-1:0]         s_pos_x,
    input  logic [ttb_pkg::FIELD_W-1:0]         s_pos_y,
    input  logic [ttb_pkg::FIELD_W-1:0]         s_pos_z,
    input  logic [ttb_pkg::FIELD_W-1:0]         s_tex_u,
    input  logic [ttb_pkg::FIELD_W-1:0]         s_tex_v,
    input  logic                                s_mesh_start,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ttb_pkg::OUT_W-1:0]    m_tangent_x,
    output logic signed [ttb_pkg::OUT_W-1:0]    m_tangent_y,
    output logic signed [ttb_pkg::OUT_W-1:0]    m_tangent_z,
    output logic signed [ttb_pkg::OUT_W-1:0]    m_binormal_x,
    output logic signed [ttb_pkg::OUT_W-1:0]    m_binormal_y,
    output logic signed [ttb_pkg::OUT_W-1:0]    m_binormal_z,
    output logic                                m_degenerate
);
    import ttb_pkg::*;

    state_t                    state_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [1:0]                count_reg;
    logic                      vec_reg;
    logic [1:0]                comp_reg;
    logic                      deg_reg;

    logic [FIELD_W-1:0]        held_reg [HELD_DEPTH];
    logic signed [DIFF_W-1:0]  ed_reg   [ED_DEPTH];
    logic signed [ACC_W-1:0]   res_reg  [RES_DEPTH];
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]          mag_reg  [3];
    logic                      neg_reg  [3];
    logic [ACC_W-1:0]          or_reg;
    logic [P_W-1:0]            p_reg;
    logic [NM_W-1:0]           nm_reg   [3];
    logic [SUM_W-1:0]          sum_reg;
    logic [SUM_W-1:0]          n_reg;
    logic [SUM_W-1:0]          r_reg;
    logic [DV_W-1:0]           rem_reg;
    logic [QB-1:0]             q_reg;
    logic signed [OUT_W-1:0]   uv_reg   [UV_DEPTH];

    logic                      m_valid_reg;
    logic signed [OUT_W-1:0]   out_reg  [UV_DEPTH];
    logic                      m_deg_reg;

    logic [FIELD_W-1:0]        in_f [CORNER_FLDS];
    logic [1:0]                cnt;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic [STEP_W-1:0]         prev;
    logic [STEP_W-1:0]         j_idx;
    logic [1:0]                ci;
    logic signed [ACC_W-1:0]   pe;
    logic [2:0]                base;
    logic signed [ACC_W-1:0]   vsel [3];
    logic [ACC_W-1:0]          mag_c [3];
    logic [STEP_W-1:0]         srch_sh;
    logic [P_W:0]              srch_pos;
    logic [ACC_W-1:0]          sh_val;
    logic [SUM_W-1:0]          root_bit;
    logic [SUM_W-1:0]          root_rb;
    logic [4:0]                root_idx;
    logic [LEN_W-1:0]          len;
    logic [STEP_W-1:0]         div_i;
    logic [DV_W-1:0]           div_dv;
    logic [QB-1:0]             q_next;
    logic [QB-1:0]             q_sat;
    logic signed [OUT_W-1:0]   q_out;
    logic                      accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign in_f[0] = s_pos_x;
    assign in_f[1] = s_pos_y;
    assign in_f[2] = s_pos_z;
    assign in_f[3] = s_tex_u;
    assign in_f[4] = s_tex_v;
    assign cnt = (s_mesh_start || count_reg == 2'd3) ? 2'd0 : count_reg;

    // multiplier operand select
    assign j_idx = step_reg >> 1;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        ci    = '0;
        if (state_reg == ST_MUL) begin
            if (j_idx == '0) begin
                mul_a = MUL_W'(step_reg[0] ? ed_reg[ED_DU2] : ed_reg[ED_DU1]);
                mul_b = MUL_W'(step_reg[0] ? ed_reg[ED_DV1] : ed_reg[ED_DV2]);
            end else if (j_idx < STEP_W'(RES_B)) begin
                ci    = 2'(j_idx - STEP_W'(RES_T));
                mul_a = MUL_W'(step_reg[0] ? ed_reg[ED_DV1] : ed_reg[ED_DV2]);
                mul_b = MUL_W'(step_reg[0] ? ed_reg[ED_E2 + int'(ci)]
                                           : ed_reg[ED_E1 + int'(ci)]);
            end else begin
                ci    = 2'(j_idx - STEP_W'(RES_B));
                mul_a = MUL_W'(step_reg[0] ? ed_reg[ED_DU2] : ed_reg[ED_DU1]);
                mul_b = MUL_W'(step_reg[0] ? ed_reg[ED_E1 + int'(ci)]
                                           : ed_reg[ED_E2 + int'(ci)]);
            end
        end else if (state_reg == ST_SQR && step_reg < STEP_W'(SQ_STEPS)) begin
            mul_a = MUL_W'($signed({1'b0, nm_reg[step_reg[1:0]]}));
            mul_b = mul_a;
        end
    end

    assign prev = step_reg - 1'b1;
    assign pe   = ACC_W'($signed(prod_reg[2*DIFF_W-1:0]));

    // magnitudes of the selected vector
    assign base = vec_reg ? 3'(RES_B) : 3'(RES_T);
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vsel[i]  = res_reg[int'(base) + i];
            mag_c[i] = vsel[i][ACC_W-1] ? $unsigned(-vsel[i]) : $unsigned(vsel[i]);
        end
    end

    assign srch_sh  = STEP_W'(P_W) - step_reg;
    assign srch_pos = (P_W+1)'(p_reg) + ((P_W+1)'(1) << srch_sh);

    always_comb begin
        if (p_reg > P_W'(NORM_TOP))
            sh_val = mag_reg[step_reg[1:0]] >> (p_reg - P_W'(NORM_TOP));
        else
            sh_val = mag_reg[step_reg[1:0]] << (P_W'(NORM_TOP) - p_reg);
    end

    assign root_idx = 5'(STEP_W'(ROOT_STEPS) - step_reg);
    assign root_bit = SUM_W'(1) << {root_idx, 1'b0};
    assign root_rb  = r_reg + root_bit;

    assign len    = r_reg[LEN_W-1:0];
    assign div_i  = STEP_W'(QB) - step_reg;
    assign div_dv = DV_W'(len) << div_i;
    always_comb begin
        q_next = q_reg;
        if (rem_reg >= div_dv)
            q_next = q_reg | (QB'(1) << div_i);
        q_sat = (q_next > (QB'(1) << UNIT_FRAC)) ? (QB'(1) << UNIT_FRAC) : q_next;
        q_out = neg_reg[comp_reg] ? -OUT_W'(q_sat) : OUT_W'(q_sat);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
            vec_reg     <= 1'b0;
            comp_reg    <= '0;
        end else begin
            // the finish step reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != ST_FINISH)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (cnt < 2'd2) begin
                            for (int c = 0; c < 2; c++)
                                for (int f = 0; f < CORNER_FLDS; f++)
                                    if (cnt == 2'(c))
                                        held_reg[c*CORNER_FLDS + f] <= in_f[f];
                            count_reg <= cnt + 1'b1;
                        end else begin
                            for (int f = 0; f < 3; f++) begin
                                ed_reg[ED_E1 + f] <= coord_diff(held_reg[CORNER_FLDS + f],
                                                                held_reg[f]);
                                ed_reg[ED_E2 + f] <= coord_diff(in_f[f], held_reg[f]);
                            end
                            ed_reg[ED_DU1] <= coord_diff(held_reg[CORNER_FLDS + 3],
                                                         held_reg[3]);
                            ed_reg[ED_DV1] <= coord_diff(held_reg[CORNER_FLDS + 4],
                                                         held_reg[4]);
                            ed_reg[ED_DU2] <= coord_diff(in_f[3], held_reg[3]);
                            ed_reg[ED_DV2] <= coord_diff(in_f[4], held_reg[4]);
                            count_reg <= '0;
                            deg_reg   <= 1'b0;
                            step_reg  <= '0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    // product issued at step s is consumed at step s+1
                    if (step_reg != '0) begin
                        if (!prev[0])
                            acc_reg <= pe;
                        else
                            res_reg[3'(prev >> 1)] <= acc_reg - pe;
                    end
                    if (step_reg == STEP_W'(MUL_STEPS)) begin
                        step_reg <= '0;
                        vec_reg  <= 1'b0;
                        if (res_reg[RES_DET] == '0) begin
                            deg_reg   <= 1'b1;
                            state_reg <= ST_FINISH;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (step_reg == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            mag_reg[i] <= mag_c[i];
                            neg_reg[i] <= vsel[i][ACC_W-1] ^ res_reg[RES_DET][ACC_W-1];
                        end
                        or_reg <= mag_c[0] | mag_c[1] | mag_c[2];
                        p_reg  <= '0;
                        if ((mag_c[0] | mag_c[1] | mag_c[2]) == '0) begin
                            deg_reg   <= 1'b1;
                            state_reg <= ST_FINISH;
                        end else begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end else begin
                        // binary search for the top set bit
                        if ((or_reg >> srch_pos) != '0)
                            p_reg <= P_W'(srch_pos);
                        if (step_reg == STEP_W'(P_W)) begin
                            step_reg  <= '0;
                            state_reg <= ST_SHIFT;
                        end else begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                ST_SHIFT: begin
                    nm_reg[step_reg[1:0]] <= sh_val[NM_W-1:0];
                    if (step_reg == STEP_W'(2)) begin
                        step_reg  <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_SQR;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SQR: begin
                    if (step_reg != '0)
                        sum_reg <= sum_reg + prod_reg[SUM_W-1:0];
                    if (step_reg == STEP_W'(SQ_STEPS)) begin
                        step_reg  <= '0;
                        state_reg <= ST_ROOT;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_ROOT: begin
                    if (step_reg == '0) begin
                        n_reg <= sum_reg;
                        r_reg <= '0;
                    end else if (n_reg >= root_rb) begin
                        n_reg <= n_reg - root_rb;
                        r_reg <= (r_reg >> 1) + root_bit;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    if (step_reg == STEP_W'(ROOT_STEPS)) begin
                        step_reg  <= '0;
                        comp_reg  <= '0;
                        state_reg <= ST_DIV;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_DIV: begin
                    if (step_reg == '0) begin
                        rem_reg  <= (DV_W'(nm_reg[comp_reg]) << UNIT_FRAC)
                                    + DV_W'(len >> 1);
                        q_reg    <= '0;
                        if (len == '0) begin
                            deg_reg   <= 1'b1;
                            state_reg <= ST_FINISH;
                        end else begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end else begin
                        if (rem_reg >= div_dv)
                            rem_reg <= rem_reg - div_dv;
                        q_reg <= q_next;
                        if (step_reg == STEP_W'(QB)) begin
                            uv_reg[3*int'(vec_reg) + int'(comp_reg)] <= q_out;
                            step_reg <= '0;
                            if (comp_reg != 2'd2) begin
                                comp_reg <= comp_reg + 1'b1;
                            end else if (!vec_reg) begin
                                vec_reg   <= 1'b1;
                                state_reg <= ST_SCAN;
                            end else begin
                                state_reg <= ST_FINISH;
                            end
                        end else begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        for (int i = 0; i < UV_DEPTH; i++)
                            out_reg[i] <= deg_reg ? '0 : uv_reg[i];
                        m_deg_reg   <= deg_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_tangent_x  = out_reg[0];
    assign m_tangent_y  = out_reg[1];
    assign m_tangent_z  = out_reg[2];
    assign m_binormal_x = out_reg[3];
    assign m_binormal_y = out_reg[4];
    assign m_binormal_z = out_reg[5];
    assign m_degenerate = m_deg_reg;

    // a finished triangle lands in the output register once it is free
    a_finish_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("finished result not loaded");

    // vertices are only taken when the sequencer is parked
    a_busy_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("request taken while busy");

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_deg_reg) |->
        (out_reg[0] == '0 && out_reg[1] == '0 && out_reg[2] == '0 &&
         out_reg[3] == '0 && out_reg[4] == '0 && out_reg[5] == '0))
        else $error("degenerate result with nonzero vector");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_deg_reg) |->
        (out_reg[0] <= OUT_W'(1 << UNIT_FRAC) && out_reg[0] >= -OUT_W'(1 << UNIT_FRAC)))
        else $error("tangent component out of unit range");

endmodule
